FILE: rtl/pspf_pkg.sv
// Shared constants and types of the particle sensor frame parser.
`timescale 1ns / 1ps

package pspf_pkg;

  localparam int FrameLen    = 24;
  localparam int PosW        = $clog2(FrameLen);
  localparam int ChkHiPos    = FrameLen - 2;
  localparam int LastPos     = FrameLen - 1;
  localparam int ReadFirst   = 4;
  localparam int NumReadings = 6;
  localparam int ReadBytes   = 2 * NumReadings;
  localparam int ReadLast    = ReadFirst + ReadBytes - 1;
  localparam int RdIdxW      = $clog2(ReadBytes);

  localparam logic [7:0] HdrFirst  = 8'h42;
  localparam logic [7:0] HdrSecond = 8'h4d;

  typedef enum logic [1:0] {
    StPending  = 2'd0,
    StValid    = 2'd1,
    StMismatch = 2'd2
  } status_e;

  typedef struct packed {
    status_e                          status;
    logic [NumReadings-1:0][15:0]     pm;
  } result_t;

endpackage

FILE: rtl/pspf_parser.sv
// Input byte register, header hunt, byte sum and frame checking.
`timescale 1ns / 1ps

module pspf_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output pspf_pkg::result_t res_o
);

  logic                      byte_vld_q, byte_vld_d;
  logic [7:0]                byte_q;
  logic [pspf_pkg::PosW-1:0] pos_q, pos_d;
  logic [15:0]               sum_q, sum_d;
  logic [7:0]                chk_hi_q;
  logic [7:0]                rd_q [pspf_pkg::ReadBytes];
  logic                      consume;
  logic                      in_rd_range;
  logic [pspf_pkg::PosW-1:0] rd_off;
  logic [15:0]               sum_add;
  logic [15:0]               check;

  assign consume    = byte_vld_q && !res_stall_i;
  assign in_stall_o = byte_vld_q && res_stall_i;

  assign byte_vld_d = in_stall_o ? byte_vld_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      pos_q      <= '0;
      sum_q      <= '0;
    end else begin
      byte_vld_q <= byte_vld_d;
      if (consume) begin
        pos_q <= pos_d;
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign rd_off      = pos_q - pspf_pkg::PosW'(pspf_pkg::ReadFirst);
  assign in_rd_range = (pos_q >= pspf_pkg::PosW'(pspf_pkg::ReadFirst)) &&
                       (pos_q <= pspf_pkg::PosW'(pspf_pkg::ReadLast));

  // Keep only the reading bytes and the checksum high byte.
  always_ff @(posedge clk_i) begin
    if (consume && in_rd_range) begin
      rd_q[rd_off[pspf_pkg::RdIdxW-1:0]] <= byte_q;
    end
    if (consume && pos_q == pspf_pkg::PosW'(pspf_pkg::ChkHiPos)) begin
      chk_hi_q <= byte_q;
    end
  end

  assign sum_add = sum_q + {8'h00, byte_q};
  assign check   = {chk_hi_q, byte_q};

  // Next position and sum.
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (pos_q == '0) begin
      if (byte_q == pspf_pkg::HdrFirst) begin
        pos_d = pspf_pkg::PosW'(1);
        sum_d = {8'h00, byte_q};
      end
    end else if (pos_q == pspf_pkg::PosW'(1)) begin
      // drop back to the hunt without re-testing this byte
      if (byte_q == pspf_pkg::HdrSecond) begin
        pos_d = pspf_pkg::PosW'(2);
        sum_d = sum_add;
      end else begin
        pos_d = '0;
      end
    end else if ({1'b0, pos_q} >= (pspf_pkg::PosW + 1)'(pspf_pkg::FrameLen)) begin
      pos_d = '0;
    end else begin
      if (pos_q < pspf_pkg::PosW'(pspf_pkg::ChkHiPos)) begin
        sum_d = sum_add;
      end
      if (pos_q == pspf_pkg::PosW'(pspf_pkg::LastPos)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + pspf_pkg::PosW'(1);
      end
    end
  end

  // Result of the byte being consumed.
  always_comb begin
    res_o.status = pspf_pkg::StPending;
    res_o.pm     = '0;
    if (pos_q == pspf_pkg::PosW'(pspf_pkg::LastPos)) begin
      if (check == sum_q) begin
        res_o.status = pspf_pkg::StValid;
        for (int k = 0; k < pspf_pkg::NumReadings; k++) begin
          res_o.pm[k] = {rd_q[2*k], rd_q[2*k+1]};
        end
      end else begin
        res_o.status = pspf_pkg::StMismatch;
      end
    end
  end

  assign res_valid_o = byte_vld_q;

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < (pspf_pkg::PosW + 1)'(pspf_pkg::FrameLen))
    else $error("frame position out of range");

  a_done_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != pspf_pkg::StPending
      |-> pos_q == pspf_pkg::PosW'(pspf_pkg::LastPos))
    else $error("frame status reported before last byte");

  a_hunt_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && pos_q == '0 && byte_q != pspf_pkg::HdrFirst |=> pos_q == '0)
    else $error("hunt left without header byte");

  a_restart_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && pos_q == pspf_pkg::PosW'(pspf_pkg::LastPos) |=> pos_q == '0)
    else $error("position not cleared after frame end");

endmodule

FILE: rtl/pspf_out_reg.sv
// Result register that drives the output channel.
`timescale 1ns / 1ps

module pspf_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  output logic              res_stall_o,
  input  pspf_pkg::result_t res_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pspf_pkg::result_t out_o
);

  logic              out_vld_q;
  pspf_pkg::result_t out_q;
  logic              load;

  assign res_stall_o = out_vld_q && out_stall_i;
  assign load        = res_valid_i && !res_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!res_stall_o) begin
      out_vld_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  a_pm_zero_unless_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status != pspf_pkg::StValid |-> out_q.pm == '0)
    else $error("readings nonzero on a frame without valid status");

  a_load_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_vld_q && out_q == $past(res_i))
    else $error("result register missed a request");

endmodule

FILE: rtl/particle_sensor_frame_parser.sv
// Top level of the particle sensor serial frame parser.
//
// Input channel: one received serial byte per request on rx_byte_i, taken
// at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: one status request per input byte. status_o is pending
// (0) for every byte but the last of a frame, then valid frame (1) or
// checksum mismatch (2). The six readings are nonzero only on a valid frame.
// The result of an accepted byte is formed from the input register and
// registered in the result register, which drives out_valid_o.
// Throughput: one byte per cycle unless the receiver stalls; each byte passes
// the input register, the header/count/sum logic and the result register, and
// the running byte sum keeps that logic to one 16-bit add and compare.
// Reset clears the frame position, the sum and both valid flags; the parser
// starts in the header hunt.
// When the receiver stalls a waiting result, the result register holds and
// in_stall_o rises in the same cycle if the input register holds a byte;
// if it is empty, one more byte is taken into it first.
`timescale 1ns / 1ps

module particle_sensor_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] pm1_std_o,
  output logic [15:0] pm25_std_o,
  output logic [15:0] pm10_std_o,
  output logic [15:0] pm1_atm_o,
  output logic [15:0] pm25_atm_o,
  output logic [15:0] pm10_atm_o
);

  logic              res_valid;
  logic              res_stall;
  pspf_pkg::result_t res;
  pspf_pkg::result_t out;

  pspf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_stall_i (res_stall),
    .res_o       (res)
  );

  pspf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_stall_o (res_stall),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign status_o   = out.status;
  assign pm1_std_o  = out.pm[0];
  assign pm25_std_o = out.pm[1];
  assign pm10_std_o = out.pm[2];
  assign pm1_atm_o  = out.pm[3];
  assign pm25_atm_o = out.pm[4];
  assign pm10_atm_o = out.pm[5];

endmodule

FILE: sim/particle_sensor_frame_parser_test.sv
// Self-checking testbench for the particle sensor serial frame parser.
`timescale 1ns / 1ps

module particle_sensor_frame_parser_test;

  import pspf_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 200;
  localparam int ByteTarget = 1200;

  typedef enum int {
    FrmGood,
    FrmBadSum,
    FrmCut
  } frame_kind_e;

  // Tracks the parser's frame position and byte sum, and queues one status per byte.
  class frame_tracker;
    int          frame_pos;
    logic [15:0] byte_sum;
    logic [7:0]  frame_buf [FrameLen];
    result_t     status_q [$];
    int          errors;
    int          bytes_seen;
    int          valid_frames;
    int          bad_frames;
    int          checked;
    string       pm_name [NumReadings] = '{"pm1_std", "pm25_std", "pm10_std",
                                           "pm1_atm", "pm25_atm", "pm10_atm"};

    function void note_byte(logic [7:0] b);
      result_t r;
      r.status = StPending;
      r.pm     = '0;
      bytes_seen++;
      if (frame_pos == 0) begin
        if (b == HdrFirst) begin
          frame_buf[0] = b;
          byte_sum     = 16'(b);
          frame_pos    = 1;
        end
      end else if (frame_pos == 1) begin
        // a wrong second header byte is not retried as a first one
        if (b == HdrSecond) begin
          frame_buf[1] = b;
          byte_sum     = byte_sum + 16'(b);
          frame_pos    = 2;
        end else begin
          frame_pos = 0;
        end
      end else begin
        frame_buf[frame_pos] = b;
        if (frame_pos < ChkHiPos) byte_sum = byte_sum + 16'(b);
        if (frame_pos < LastPos) begin
          frame_pos++;
        end else begin
          frame_pos = 0;
          if ({frame_buf[ChkHiPos], b} == byte_sum) begin
            r.status = StValid;
            for (int k = 0; k < NumReadings; k++)
              r.pm[k] = {frame_buf[ReadFirst + 2 * k], frame_buf[ReadFirst + 2 * k + 1]};
            valid_frames++;
          end else begin
            r.status = StMismatch;
            bad_frames++;
          end
        end
      end
      status_q.push_back(r);
    endfunction

    function void check_status(result_t got);
      result_t want;
      if (status_q.size() == 0) begin
        $error("unexpected result: status %0d with nothing outstanding", got.status);
        errors++;
        return;
      end
      want = status_q.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      for (int k = 0; k < NumReadings; k++) begin
        if (got.pm[k] !== want.pm[k]) begin
          $error("%s: expected 0x%04h, got 0x%04h", pm_name[k], want.pm[k], got.pm[k]);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return status_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [15:0] pm1_std;
  logic [15:0] pm25_std;
  logic [15:0] pm10_std;
  logic [15:0] pm1_atm;
  logic [15:0] pm25_atm;
  logic [15:0] pm10_atm;

  frame_tracker tracker = new();
  bit           hold_req;
  int           burst_left;
  int           cycle_count;

  particle_sensor_frame_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .rx_byte_i  (rx_byte),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .status_o   (status),
    .pm1_std_o  (pm1_std),
    .pm25_std_o (pm25_std),
    .pm10_std_o (pm10_std),
    .pm1_atm_o  (pm1_atm),
    .pm25_atm_o (pm25_atm),
    .pm10_atm_o (pm10_atm)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("particle_sensor_frame_parser_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid === 1'b1 && out_stall == 1'b0) begin
      got.status = status_e'(status);
      got.pm     = {pm10_atm, pm25_atm, pm1_atm, pm10_std, pm25_std, pm1_std};
      tracker.check_status(got);
    end
  end

  // Receiver: stall in random modes, or hold off for a long stretch on request.
  initial begin : receiver
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 80);
        end
        left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    tracker.note_byte(b);
  endtask

  task automatic send_frame(input frame_kind_e kind, input bit extreme);
    logic [7:0]  frm [FrameLen];
    logic [15:0] sum;
    int          pick;
    int          count;
    frm[0] = HdrFirst;
    frm[1] = HdrSecond;
    // length word is not checked by the block; mostly send the real one
    pick   = $urandom_range(0, 3);
    frm[2] = (pick == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
    frm[3] = (pick == 0) ? 8'($urandom_range(0, 255)) : 8'(FrameLen - 4);
    for (int i = ReadFirst; i < ChkHiPos; i++) begin
      if (extreme) begin
        frm[i] = (i > ReadLast || ((i - ReadFirst) / 2) % 2 == 0) ? 8'hff : 8'h00;
      end else begin
        pick   = $urandom_range(0, 5);
        frm[i] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom_range(0, 255));
      end
    end
    sum = '0;
    for (int i = 0; i < ChkHiPos; i++) sum = sum + 16'(frm[i]);
    frm[ChkHiPos] = sum[15:8];
    frm[LastPos]  = sum[7:0];
    if (kind == FrmBadSum) begin
      pick      = $urandom_range(2, LastPos);
      frm[pick] = frm[pick] ^ 8'(1 << $urandom_range(0, 7));
    end
    count = (kind == FrmCut) ? $urandom_range(1, LastPos) : FrameLen;
    for (int i = 0; i < count; i++) send_byte(frm[i]);
  endtask

  initial begin : stimulus
    int kind;
    int frames;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    rx_byte   = '0;
    out_stall = 1'b0;
    hold_req  = 1'b0;
    frames    = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // hunt: drop stray bytes, including a lone second header byte
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(HdrSecond);
    // wrong second header byte, then one that must not restart the hunt
    send_byte(HdrFirst);
    send_byte(8'h00);
    send_byte(HdrFirst);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    // full-scale and zero readings in one good frame
    send_frame(FrmGood, 1'b1);

    while (tracker.bytes_seen < ByteTarget) begin
      frames++;
      if (frames == 8 || frames == 30) hold_req = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_frame(FrmGood, 1'b0);
      end else if (kind < 80) begin
        send_frame(FrmBadSum, 1'b0);
      end else if (kind < 88) begin
        send_frame(FrmCut, 1'b0);
      end else if (kind < 94) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(HdrFirst);
        if ($urandom_range(0, 1) == 0) begin
          send_byte(HdrFirst);
          send_byte(HdrSecond);
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes in %0d random sequences; checked %0d status results.",
             tracker.bytes_seen, frames, tracker.checked);
    $display("Frames ending valid: %0d, with checksum mismatch: %0d.",
             tracker.valid_frames, tracker.bad_frames);
    if (tracker.errors == 0) begin
      $display("particle_sensor_frame_parser_test OK");
    end else begin
      $display("particle_sensor_frame_parser_test NOT OK");
    end
    $finish;
  end

endmodule
